// ===== design/rvps_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotated frame-store scan-out: shared package
// Geometry constants, request codes, register indices, the configuration and
// pixel request structures, and the palette packing and reset functions.
// ----------------------------------------------------------------------------
package rvps_pkg;

  localparam int DISP_WIDTH  = 256;
  localparam int DISP_HEIGHT = 216;
  localparam int TOP_LINES   = 8;
  localparam int SCAN_ROWS   = TOP_LINES + DISP_HEIGHT;
  localparam int STORE_SIZE  = 256 * (TOP_LINES + 256);
  localparam int ROT_BASE    = 256 * TOP_LINES;
  localparam int STORE_AW    = 17;
  localparam int INDEX_W     = 9;
  localparam int LEN_W       = INDEX_W + 1;
  localparam int COORD_W     = 16;
  localparam int COLOR_W     = 16;
  localparam int PAL_DEPTH   = 256;
  localparam int CFG_IDX_W   = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PW     = 2;
  localparam int FIFO_CW     = 3;

  typedef enum logic [1:0] {
    REQ_STORE_WRITE   = 2'd0,
    REQ_PALETTE_WRITE = 2'd1,
    REQ_RESTART       = 2'd2,
    REQ_PIXEL         = 2'd3
  } req_t;

  localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACROSS_STEP_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACROSS_STEP_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_STEP_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_STEP_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZ_MODE    = 3'd6;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] across_step_x;
    logic [COORD_W-1:0] across_step_y;
    logic [COORD_W-1:0] down_step_x;
    logic [COORD_W-1:0] down_step_y;
    logic               horizontal_mode;
  } scan_cfg_t;

  typedef struct packed {
    logic [STORE_AW-1:0] addr;
    logic                sweep_end;
    logic                frame_end;
  } pixel_req_t;

  function automatic logic [COLOR_W-1:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // Entries 0 to 7 are full primaries, 8 to 15 half primaries, the rest white.
  function automatic logic [COLOR_W-1:0] palette_reset_value(input logic [7:0] slot);
    logic [COLOR_W-1:0] value;
    value = '1;
    if (slot[7:4] == 4'd0) begin
      if (slot[3]) begin
        value = {slot[1] ? 5'h10 : 5'h00, slot[2] ? 6'h20 : 6'h00, slot[0] ? 5'h10 : 5'h00};
      end else begin
        value = {slot[1] ? 5'h1f : 5'h00, slot[2] ? 6'h3f : 6'h00, slot[0] ? 5'h1f : 5'h00};
      end
    end
    return value;
  endfunction

endpackage

// ===== design/rvps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered, read-first data.
// ----------------------------------------------------------------------------
module rvps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rvps_scan.sv =====
// ----------------------------------------------------------------------------
// Scan position generator
// Holds the sweep indices and the fixed-point line and point accumulators,
// and forms the frame store address and end flags of the current pixel.
// ----------------------------------------------------------------------------
module rvps_scan import rvps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  scan_cfg_t  cfg,
  input  logic       restart,
  input  logic       step,
  output pixel_req_t pix
);

  logic [INDEX_W-1:0] outer_index;
  logic [INDEX_W-1:0] inner_index;
  logic [COORD_W-1:0] line_x;
  logic [COORD_W-1:0] line_y;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;

  logic               horiz;
  logic [LEN_W-1:0]   inner_len;
  logic [LEN_W-1:0]   outer_len;
  logic [LEN_W-1:0]   inner_inc;
  logic [LEN_W-1:0]   outer_inc;
  logic [INDEX_W-1:0] row;
  logic [INDEX_W-1:0] col;
  logic [COORD_W-1:0] in_dx;
  logic [COORD_W-1:0] in_dy;
  logic [COORD_W-1:0] out_dx;
  logic [COORD_W-1:0] out_dy;
  logic               top;
  logic               first;
  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;
  logic               sweep_last;
  logic               frame_last;

  always_comb begin
    horiz     = cfg.horizontal_mode;
    inner_len = horiz ? LEN_W'(SCAN_ROWS) : LEN_W'(DISP_WIDTH);
    outer_len = horiz ? LEN_W'(DISP_WIDTH) : LEN_W'(SCAN_ROWS);
    row       = horiz ? inner_index : outer_index;
    col       = horiz ? outer_index : inner_index;
    in_dx     = horiz ? cfg.down_step_x : cfg.across_step_x;
    in_dy     = horiz ? cfg.down_step_y : cfg.across_step_y;
    out_dx    = horiz ? cfg.across_step_x : cfg.down_step_x;
    out_dy    = horiz ? cfg.across_step_y : cfg.down_step_y;
    top       = row < INDEX_W'(TOP_LINES);
    first     = horiz ? (inner_index == INDEX_W'(TOP_LINES)) : (inner_index == '0);
    px        = first ? line_x : point_x;
    py        = first ? line_y : point_y;
    inner_inc = {1'b0, inner_index} + LEN_W'(1);
    outer_inc = {1'b0, outer_index} + LEN_W'(1);
    sweep_last = inner_inc >= inner_len;
    frame_last = sweep_last && (outer_inc >= outer_len);

    if (top) begin
      pix.addr = {row, col[7:0]};
    end else begin
      pix.addr = STORE_AW'(ROT_BASE) + {1'b0, py[15:8], px[15:8]};
    end
    pix.sweep_end = sweep_last;
    pix.frame_end = frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_index <= '0;
      inner_index <= '0;
      line_x      <= '0;
      line_y      <= '0;
      point_x     <= '0;
      point_y     <= '0;
    end else if (restart) begin
      line_x      <= cfg.start_x;
      line_y      <= cfg.start_y;
      outer_index <= '0;
      inner_index <= '0;
    end else if (step) begin
      if (!top) begin
        point_x <= px + in_dx;
        point_y <= py + in_dy;
      end
      if (frame_last) begin
        line_x      <= cfg.start_x;
        line_y      <= cfg.start_y;
        outer_index <= '0;
        inner_index <= '0;
      end else if (sweep_last) begin
        if (horiz || !top) begin
          line_x <= line_x + out_dx;
          line_y <= line_y + out_dy;
        end
        inner_index <= '0;
        outer_index <= outer_inc[INDEX_W-1:0];
      end else begin
        inner_index <= inner_inc[INDEX_W-1:0];
      end
    end
  end

endmodule

// ===== design/rotated_vram_palette_scanout.sv =====
// ----------------------------------------------------------------------------
// Rotated frame-store scan-out with RGB565 palette
// Byte-per-pixel frame store with a straight top band and a rotated,
// wrapping 256x256 area, looked up through a 256-entry RGB565 palette.
//
//   Channel | Direction | Handshake              | Content
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid / in_ready    | request and write payload
//   out     | output    | out_valid / out_ready  | color, sweep_end, frame_end
//   cfg     | input     | cfg_write              | cfg_index, cfg_data
//
// One input transaction is taken per cycle while in_ready is high. A pixel
// tick reaches the output after the registered frame store read, the
// registered palette read and the write into the output queue.
// A four-entry output queue absorbs stalls; input is held off whenever four
// pixel transactions are in flight between the two read stages and the queue.
// After reset the frame store's 67584 bytes are cleared one byte per cycle;
// no input transaction is taken until the clear is done.
// ----------------------------------------------------------------------------
module rotated_vram_palette_scanout import rvps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           req_type,
  input  logic [STORE_AW-1:0]  store_address,
  input  logic [7:0]           store_byte,
  input  logic [7:0]           palette_slot,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COLOR_W-1:0]   color,
  output logic                 sweep_end,
  output logic                 frame_end
);

  scan_cfg_t           cfg;
  pixel_req_t          pix;
  logic                in_accept;
  logic                is_pixel;
  logic                clearing;
  logic [STORE_AW-1:0] clear_addr;
  logic                fs_we;
  logic [STORE_AW-1:0] fs_waddr;
  logic [7:0]          fs_wdata;
  logic [7:0]          fs_rdata;
  logic                pal_we;
  logic [COLOR_W-1:0]  pal_rdata;
  logic [PAL_DEPTH-1:0] pal_written;
  logic                pal_hit;
  logic [COLOR_W-1:0]  pal_default;
  logic                s1_valid;
  logic                s1_sweep;
  logic                s1_frame;
  logic                s2_valid;
  logic                s2_sweep;
  logic                s2_frame;
  logic [COLOR_W-1:0]  s2_color;
  logic [COLOR_W-1:0]  fifo_color [FIFO_DEPTH];
  logic                fifo_sweep [FIFO_DEPTH];
  logic                fifo_frame [FIFO_DEPTH];
  logic [FIFO_PW-1:0]  wr_ptr;
  logic [FIFO_PW-1:0]  rd_ptr;
  logic [FIFO_CW-1:0]  fifo_count;
  logic [FIFO_CW-1:0]  in_flight;
  logic                pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_x         <= '0;
      cfg.start_y         <= '0;
      cfg.across_step_x   <= COORD_W'(256);
      cfg.across_step_y   <= '0;
      cfg.down_step_x     <= '0;
      cfg.down_step_y     <= COORD_W'(256);
      cfg.horizontal_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_X:       cfg.start_x         <= cfg_data;
        REG_START_Y:       cfg.start_y         <= cfg_data;
        REG_ACROSS_STEP_X: cfg.across_step_x   <= cfg_data;
        REG_ACROSS_STEP_Y: cfg.across_step_y   <= cfg_data;
        REG_DOWN_STEP_X:   cfg.down_step_x     <= cfg_data;
        REG_DOWN_STEP_Y:   cfg.down_step_y     <= cfg_data;
        REG_HORIZ_MODE:    cfg.horizontal_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_flight = fifo_count + FIFO_CW'(s1_valid) + FIFO_CW'(s2_valid);
    in_ready  = !clearing && (in_flight < FIFO_CW'(FIFO_DEPTH));
    in_accept = in_valid && in_ready;
    is_pixel  = in_accept && (req_type == REQ_PIXEL);
    pop       = out_valid && out_ready;
  end

  rvps_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (in_accept && (req_type == REQ_RESTART)),
    .step    (is_pixel),
    .pix     (pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + STORE_AW'(1);
      if (clear_addr == STORE_AW'(STORE_SIZE - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      fs_we    = 1'b1;
      fs_waddr = clear_addr;
      fs_wdata = '0;
    end else begin
      fs_we    = in_accept && (req_type == REQ_STORE_WRITE) &&
                 (store_address < STORE_AW'(STORE_SIZE));
      fs_waddr = store_address;
      fs_wdata = store_byte;
    end
  end

  rvps_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_frame_store (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .re    (is_pixel),
    .raddr (pix.addr),
    .rdata (fs_rdata)
  );

  assign pal_we = in_accept && (req_type == REQ_PALETTE_WRITE);

  rvps_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (palette_slot),
    .wdata (pack565(red, green, blue)),
    .re    (s1_valid),
    .raddr (fs_rdata),
    .rdata (pal_rdata)
  );

  // An entry never written reads as its reset colour.
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_written <= '0;
    end else if (pal_we) begin
      pal_written[palette_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      pal_hit     <= pal_written[fs_rdata];
      pal_default <= palette_reset_value(fs_rdata);
      s2_sweep    <= s1_sweep;
      s2_frame    <= s1_frame;
    end
    if (is_pixel) begin
      s1_sweep <= pix.sweep_end;
      s1_frame <= pix.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= is_pixel;
      s2_valid <= s1_valid;
    end
  end

  assign s2_color = pal_hit ? pal_rdata : pal_default;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      fifo_color[wr_ptr] <= s2_color;
      fifo_sweep[wr_ptr] <= s2_sweep;
      fifo_frame[wr_ptr] <= s2_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + FIFO_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PW'(1);
      end
      fifo_count <= fifo_count + FIFO_CW'(s2_valid) - FIFO_CW'(pop);
    end
  end

  assign out_valid = fifo_count != '0;
  assign color     = fifo_color[rd_ptr];
  assign sweep_end = fifo_sweep[rd_ptr];
  assign frame_end = fifo_frame[rd_ptr];

endmodule
